### rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the bit packing encoder: request codes,
// the command record passed from the classifier to the packer, field widths.
// ----------------------------------------------------------------------------
package bpe_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int MAX_INDEX_DEFAULT   = 63;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int FIELD_W   = 32;   // value field
   localparam int NB_W      = 6;    // num_bits, block_size, index fields
   localparam int OP_W      = 3;
   localparam int ZCNT_W    = 9;    // zero run length, up to 64
   localparam int BYTE_W    = 8;
   localparam int REQ_TDATA_W = 56; // 50 field bits padded to whole bytes

   localparam logic [OP_W-1:0] OP_RAW    = 3'd0;
   localparam logic [OP_W-1:0] OP_INDEX  = 3'd1;
   localparam logic [OP_W-1:0] OP_ESCAPE = 3'd2;
   localparam logic [OP_W-1:0] OP_VALUE  = 3'd3;
   localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

   // escape is the unary code for 2 (two zeros, then a one)
   localparam logic [ZCNT_W-1:0] ESCAPE_ZEROS = 9'd2;

   typedef enum logic [2:0] {
      CMD_RAW,
      CMD_UNARY,
      CMD_VALUE,
      CMD_FLUSH,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [FIELD_W-1:0]   value;
      logic [NB_W-1:0]      num_bits;
      logic [NB_W-1:0]      block_size;
      logic [ZCNT_W-1:0]    zeros;
   } cmd_type;

endpackage

### rtl/bit_packing_value_index_encoder.sv
// A request is written into the command queue at its accepting edge and the packer takes it
// once idle; each byte waits until the next byte completes or the request closes. The packer
// takes one command at a time and packs it piece by piece (byte completed or bits placed, a
// block and a marker step per value block), closing a request that emitted bytes in a step of
// its own; it holds while the output byte waits to be taken.
// Reset: synchronous; empties the queue and restarts the stream at a fresh byte.
// ----------------------------------------------------------------------------
// bit_packing_value_index_encoder
// Packs raw fields, unary index codes and block-coded values into a byte
// stream, one byte per result; a malformed request gives an error result.
// ----------------------------------------------------------------------------
module bit_packing_value_index_encoder #(
   parameter int VALUE_WIDTH = bpe_pkg::VALUE_WIDTH_DEFAULT,
   parameter int MAX_INDEX   = bpe_pkg::MAX_INDEX_DEFAULT,
   parameter int QUEUE_DEPTH = bpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value, [37:32] num_bits, [43:38] block_size, [49:44] index, rest 0
   input  logic [bpe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] op
   input  logic [bpe_pkg::OP_W-1:0]            req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] out_byte
   output logic [bpe_pkg::BYTE_W-1:0]          rsp_tdata,
   output logic                                rsp_tlast,
   // [0] error
   output logic                                rsp_tuser
);

   logic               q_ready;
   logic               q_push;
   bpe_pkg::cmd_type   q_push_cmd;
   logic               q_valid;
   logic               q_pop;
   bpe_pkg::cmd_type   q_pop_cmd;

   bpe_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_INDEX   (MAX_INDEX)
   ) u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_op         (req_tuser),
      .req_value      (req_tdata[31:0]),
      .req_num_bits   (req_tdata[37:32]),
      .req_block_size (req_tdata[43:38]),
      .req_index      (req_tdata[49:44]),
      .q_ready        (q_ready),
      .q_push         (q_push),
      .q_cmd          (q_push_cmd)
   );

   bpe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (q_pop_cmd)
   );

   bpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_error  (rsp_tuser)
   );

endmodule

### rtl/bpe_front.sv
// ----------------------------------------------------------------------------
// bpe_front
// Request classifier: checks each request and turns it into a packer command
// (raw field, zero run plus one, block-coded value, flush, or error).
// ----------------------------------------------------------------------------
module bpe_front #(
   parameter int VALUE_WIDTH = bpe_pkg::VALUE_WIDTH_DEFAULT,
   parameter int MAX_INDEX   = bpe_pkg::MAX_INDEX_DEFAULT
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bpe_pkg::OP_W-1:0]      req_op,
   input  logic [bpe_pkg::FIELD_W-1:0]   req_value,
   input  logic [bpe_pkg::NB_W-1:0]      req_num_bits,
   input  logic [bpe_pkg::NB_W-1:0]      req_block_size,
   input  logic [bpe_pkg::NB_W-1:0]      req_index,
   input  logic                          q_ready,
   output logic                          q_push,
   output bpe_pkg::cmd_type              q_cmd
);

   logic                            width_ok;
   logic                            bad;
   logic [bpe_pkg::NB_W-1:0]        bs_eff;
   logic [bpe_pkg::FIELD_W-1:0]     value_masked;
   logic [bpe_pkg::ZCNT_W-1:0]      idx_zeros;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      width_ok = (req_num_bits != '0) && (req_num_bits <= 6'd32)
              && ({1'b0, req_num_bits} <= 7'(VALUE_WIDTH));
      bad = (req_op > bpe_pkg::OP_FLUSH)
         || (((req_op == bpe_pkg::OP_RAW) || (req_op == bpe_pkg::OP_VALUE)) && !width_ok)
         || ((req_op == bpe_pkg::OP_VALUE) && (req_block_size > req_num_bits))
         || ((req_op == bpe_pkg::OP_INDEX) && ({2'b00, req_index} > 8'(MAX_INDEX)));

      bs_eff       = (req_block_size == '0) ? req_num_bits : req_block_size;
      value_masked = req_value & ~({bpe_pkg::FIELD_W{1'b1}} << req_num_bits);
      // zero run 2 is reserved for the escape, so indices from 2 up shift up by one
      idx_zeros    = (req_index > 6'd1) ? ({3'b000, req_index} + 9'd1)
                                        : {3'b000, req_index};

      q_cmd.value      = req_value;
      q_cmd.num_bits   = req_num_bits;
      q_cmd.block_size = bs_eff;
      q_cmd.zeros      = idx_zeros;
      q_cmd.kind       = bpe_pkg::CMD_ERROR;

      if (!bad) begin
         case (req_op)
            bpe_pkg::OP_RAW: begin
               q_cmd.kind = bpe_pkg::CMD_RAW;
            end
            bpe_pkg::OP_INDEX: begin
               q_cmd.kind = bpe_pkg::CMD_UNARY;
            end
            bpe_pkg::OP_ESCAPE: begin
               q_cmd.kind  = bpe_pkg::CMD_UNARY;
               q_cmd.zeros = bpe_pkg::ESCAPE_ZEROS;
            end
            bpe_pkg::OP_VALUE: begin
               // short value or single block: plain field, no markers
               if ((bs_eff == req_num_bits) || (req_num_bits < 6'd3)) begin
                  q_cmd.kind = bpe_pkg::CMD_RAW;
               end else begin
                  q_cmd.kind  = bpe_pkg::CMD_VALUE;
                  q_cmd.value = value_masked;
               end
            end
            default: begin
               q_cmd.kind = bpe_pkg::CMD_FLUSH;
            end
         endcase
      end
   end

endmodule

### rtl/bpe_fifo.sv
// ----------------------------------------------------------------------------
// bpe_fifo
// Short command queue between the classifier and the packer.
// ----------------------------------------------------------------------------
module bpe_fifo #(
   parameter int DEPTH = bpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bpe_pkg::cmd_type   push_cmd,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output bpe_pkg::cmd_type   pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bpe_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign ready   = (count_ff != CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/bpe_back.sv
// ----------------------------------------------------------------------------
// bpe_back
// Bit packer: runs one command at a time, splitting it into bit segments
// (raw field, block, marker, zero run, final one) and packing them into the
// current byte. Each completed byte waits in a hold register so the last
// byte of a request can be tagged when the request ends.
// ----------------------------------------------------------------------------
module bpe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  bpe_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bpe_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last,
   output logic                          rsp_error
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PACK,
      S_NEXT
   } state_type;

   // what follows once the current segment is packed
   typedef enum logic [1:0] {
      AFT_DONE,
      AFT_ONE,
      AFT_BLOCK,
      AFT_MARKER
   } after_type;

   state_type                      state_ff, state_in;
   after_type                      after_ff, after_in;
   logic [bpe_pkg::BYTE_W-1:0]     partial_ff, partial_in;
   logic [3:0]                     free_ff, free_in;
   logic [bpe_pkg::FIELD_W-1:0]    seg_ff, seg_in;
   logic [bpe_pkg::ZCNT_W-1:0]     cnt_ff, cnt_in;
   logic [bpe_pkg::FIELD_W-1:0]    val_ff, val_in;
   logic [bpe_pkg::NB_W-1:0]       rem_ff, rem_in;
   logic [bpe_pkg::NB_W-1:0]       bs_ff, bs_in;
   logic [bpe_pkg::NB_W-1:0]       nb_ff, nb_in;
   logic [1:0]                     blocks_ff, blocks_in;
   logic                           top_ff, top_in;
   logic [bpe_pkg::BYTE_W-1:0]     hold_ff, hold_in;
   logic                           hold_vld_ff, hold_vld_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [bpe_pkg::BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_err_ff, rsp_err_in;

   logic                           out_free;
   logic                           seg_done;
   logic [bpe_pkg::BYTE_W-1:0]     full_byte;
   logic [bpe_pkg::NB_W-1:0]       blk_w;
   logic [bpe_pkg::NB_W-1:0]       blk_wm1;
   logic [bpe_pkg::FIELD_W-1:0]    rem_mask;
   logic                           ends;

   function automatic logic [7:0] mask8(input logic [3:0] n);
      mask8 = 8'hFF >> (4'd8 - n);
   endfunction

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_err_ff;

   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      partial_in  = partial_ff;
      free_in     = free_ff;
      seg_in      = seg_ff;
      cnt_in      = cnt_ff;
      val_in      = val_ff;
      rem_in      = rem_ff;
      bs_in       = bs_ff;
      nb_in       = nb_ff;
      blocks_in   = blocks_ff;
      top_in      = top_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;
      q_pop       = 1'b0;
      seg_done    = 1'b0;
      full_byte   = partial_ff | (seg_ff[7:0] & mask8(free_ff));
      blk_w       = (bs_ff > rem_ff) ? rem_ff : bs_ff;
      blk_wm1     = blk_w - 6'd1;
      rem_mask    = ~({bpe_pkg::FIELD_W{1'b1}} << rem_ff);
      ends        = top_ff ? (val_ff == rem_mask) : (val_ff == '0);

      if (out_free) begin
         case (state_ff)
            S_IDLE: begin
               if (hold_vld_ff) begin
                  // close the request: its final byte carries last
                  rsp_vld_in  = 1'b1;
                  rsp_byte_in = hold_ff;
                  rsp_last_in = 1'b1;
                  rsp_err_in  = 1'b0;
                  hold_vld_in = 1'b0;
               end else if (q_valid) begin
                  q_pop = 1'b1;
                  case (q_cmd.kind)
                     bpe_pkg::CMD_RAW: begin
                        seg_in   = q_cmd.value;
                        cnt_in   = {3'b000, q_cmd.num_bits};
                        after_in = AFT_DONE;
                        state_in = S_PACK;
                     end
                     bpe_pkg::CMD_UNARY: begin
                        seg_in   = '0;
                        cnt_in   = q_cmd.zeros;
                        after_in = AFT_ONE;
                        state_in = S_PACK;
                     end
                     bpe_pkg::CMD_VALUE: begin
                        val_in    = q_cmd.value;
                        rem_in    = q_cmd.num_bits;
                        nb_in     = q_cmd.num_bits;
                        bs_in     = q_cmd.block_size;
                        blocks_in = '0;
                        after_in  = AFT_BLOCK;
                        state_in  = S_NEXT;
                     end
                     bpe_pkg::CMD_FLUSH: begin
                        if (free_ff != 4'd8) begin
                           hold_in     = partial_ff;
                           hold_vld_in = 1'b1;
                        end
                        partial_in = '0;
                        free_in    = 4'd8;
                     end
                     default: begin
                        rsp_vld_in  = 1'b1;
                        rsp_byte_in = '0;
                        rsp_last_in = 1'b1;
                        rsp_err_in  = 1'b1;
                     end
                  endcase
               end
            end

            S_PACK: begin
               if (cnt_ff == '0) begin
                  seg_done = 1'b1;
               end else if ({5'b00000, free_ff} > cnt_ff) begin
                  // segment fits: place it in the highest free positions
                  partial_in = partial_ff
                             | ((seg_ff[7:0] & mask8(cnt_ff[3:0])) << (free_ff - cnt_ff[3:0]));
                  free_in    = free_ff - cnt_ff[3:0];
                  cnt_in     = '0;
                  seg_done   = 1'b1;
               end else begin
                  // fill the byte, move it to the hold register (emitting the held one), carry the rest over
                  seg_in     = seg_ff >> free_ff;
                  cnt_in     = cnt_ff - {5'b00000, free_ff};
                  partial_in = '0;
                  free_in    = 4'd8;
                  if (hold_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_byte_in = hold_ff;
                     rsp_last_in = 1'b0;
                     rsp_err_in  = 1'b0;
                  end
                  hold_in     = full_byte;
                  hold_vld_in = 1'b1;
                  seg_done    = (cnt_ff == {5'b00000, free_ff});
               end

               if (seg_done) begin
                  case (after_ff)
                     AFT_DONE: begin
                        state_in = S_IDLE;
                     end
                     AFT_ONE: begin
                        seg_in   = 32'd1;
                        cnt_in   = 9'd1;
                        after_in = AFT_DONE;
                     end
                     default: begin
                        state_in = S_NEXT;
                     end
                  endcase
               end
            end

            S_NEXT: begin
               case (after_ff)
                  AFT_BLOCK: begin
                     seg_in   = val_ff;
                     cnt_in   = {3'b000, blk_w};
                     top_in   = val_ff[blk_wm1[4:0]];
                     val_in   = val_ff >> blk_w;
                     rem_in   = rem_ff - blk_w;
                     after_in = AFT_MARKER;
                     state_in = S_PACK;
                  end
                  AFT_MARKER: begin
                     if (rem_ff == '0) begin
                        state_in = S_IDLE;
                     end else begin
                        // marker 0 when the rest only sign-extends this block
                        seg_in = {31'd0, !ends};
                        cnt_in = 9'd1;
                        if (ends) begin
                           rem_in   = '0;
                           after_in = AFT_DONE;
                        end else begin
                           after_in = AFT_BLOCK;
                        end
                        if (blocks_ff == 2'd3) begin
                           bs_in = nb_ff;
                        end else begin
                           blocks_in = blocks_ff + 2'd1;
                           if (bs_ff > 6'd2) begin
                              bs_in = bs_ff >> 1;
                           end
                        end
                        state_in = S_PACK;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end

            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      after_ff    <= after_in;
      seg_ff      <= seg_in;
      cnt_ff      <= cnt_in;
      val_ff      <= val_in;
      rem_ff      <= rem_in;
      bs_ff       <= bs_in;
      nb_ff       <= nb_in;
      blocks_ff   <= blocks_in;
      top_ff      <= top_in;
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         partial_ff  <= '0;
         free_ff     <= 4'd8;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         partial_ff  <= partial_in;
         free_ff     <= free_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

endmodule

### test/bit_packing_value_index_encoder_tb.sv
// ----------------------------------------------------------------------------
// bit_packing_value_index_encoder_tb
// Drives raw fields, unary index codes, escapes, block-coded values, flushes
// and malformed requests into the encoder. An internal bit-level model of the
// packer predicts every output byte, which is checked in order against the
// response stream. Random request gaps and response backpressure are applied.
// ----------------------------------------------------------------------------
module bit_packing_value_index_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bpe_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [bpe_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bpe_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int RANDOM_REQUESTS = 85;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [bpe_pkg::BYTE_W-1:0] data;
      logic                       last;
      logic                       err;
   } stream_byte_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bpe_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [bpe_pkg::OP_W-1:0]         req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bpe_pkg::BYTE_W-1:0]       rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;

   // packer model state
   logic [7:0]              pack_byte;
   int                      pack_free;
   stream_byte_type         expected_bytes[$];

   bit                      gaps_on = 1'b1;
   bit                      stalls_on = 1'b1;
   int                      stall_left = 0;
   int                      stall_pick;
   int                      failures = 0;
   int                      requests_sent = 0;
   int                      invalid_sent = 0;
   int                      bytes_checked = 0;

   bit_packing_value_index_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   initial begin
      #5ms;
      $display("bit_packing_value_index_encoder regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [63:0] low_mask(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic void emit_byte();
      stream_byte_type b;
      b.data = pack_byte;
      b.last = 1'b0;
      b.err  = 1'b0;
      expected_bytes.push_back(b);
      pack_byte = '0;
      pack_free = 8;
   endfunction

   function automatic void pack_bits(logic [63:0] bits, int n);
      int f;
      while (n > 0) begin
         f = pack_free;
         if (f > n) begin
            // fits with room to spare: occupy the highest free positions
            pack_byte = pack_byte | 8'((bits & low_mask(n)) << (f - n));
            pack_free = f - n;
            n = 0;
         end else begin
            pack_byte = pack_byte | 8'(bits & low_mask(f));
            bits = bits >> f;
            n = n - f;
            emit_byte();
         end
      end
   endfunction

   function automatic void pack_unary(int zeros);
      while (zeros > 0) begin
         if (pack_free <= zeros) begin
            zeros = zeros - pack_free;
            emit_byte();
         end else begin
            pack_free = pack_free - zeros;
            zeros = 0;
         end
      end
      pack_bits(64'd1, 1);
   endfunction

   function automatic void pack_value(logic [63:0] bits, int nb, int bs);
      int remaining;
      int blocks;
      int w;
      logic [63:0] blk;
      logic [63:0] m;
      logic top;
      remaining = nb;
      blocks = 0;
      if (bs == 0)
         bs = nb;
      if (bs == nb || nb < 3) begin
         pack_bits(bits, nb);
         return;
      end
      bits = bits & low_mask(nb);
      while (remaining > 0) begin
         w = (bs > remaining) ? remaining : bs;
         blk = bits & low_mask(w);
         bits = bits >> w;
         pack_bits(blk, w);
         remaining = remaining - w;
         if (remaining > 0) begin
            m = low_mask(remaining);
            top = blk[w-1];
            // stop marker once the rest is a sign extension of this block
            if ((top && (bits & m) == m) || (!top && (bits & m) == 0)) begin
               pack_bits(64'd0, 1);
               remaining = 0;
            end else begin
               pack_bits(64'd1, 1);
            end
         end
         blocks++;
         if (blocks >= 4)
            bs = nb;
         else if (bs > 2)
            bs = bs >> 1;
      end
   endfunction

   function automatic void predict_encoding(logic [bpe_pkg::OP_W-1:0] op, logic [31:0] value,
                                            int nb, int bs, int idx);
      int first;
      bit bad;
      stream_byte_type b;
      first = expected_bytes.size();
      bad = (op > bpe_pkg::OP_FLUSH)
         || ((op == bpe_pkg::OP_RAW || op == bpe_pkg::OP_VALUE)
             && (nb < 1 || nb > 32 || nb > bpe_pkg::VALUE_WIDTH_DEFAULT))
         || (op == bpe_pkg::OP_VALUE && bs > nb)
         || (op == bpe_pkg::OP_INDEX && idx > bpe_pkg::MAX_INDEX_DEFAULT);
      if (bad) begin
         b.data = '0;
         b.last = 1'b1;
         b.err  = 1'b1;
         expected_bytes.push_back(b);
         invalid_sent++;
         return;
      end
      case (op)
         bpe_pkg::OP_RAW:    pack_bits({32'd0, value}, nb);
         bpe_pkg::OP_INDEX:  pack_unary(idx > 1 ? idx + 1 : idx);
         bpe_pkg::OP_ESCAPE: pack_unary(int'(bpe_pkg::ESCAPE_ZEROS));
         bpe_pkg::OP_VALUE:  pack_value({32'd0, value}, nb, bs);
         default: begin
            if (pack_free != 8)
               emit_byte();
            pack_byte = '0;
            pack_free = 8;
         end
      endcase
      if (expected_bytes.size() > first)
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endfunction

   // --------------------------------------------------------------- drivers

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(logic [bpe_pkg::OP_W-1:0] op, logic [31:0] value,
                               logic [5:0] nb, logic [5:0] bs, logic [5:0] idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, idx, bs, nb, value};
      do
         @(posedge clock);
      while (!req_tready);
      predict_encoding(op, value, nb, bs, idx);
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // backpressure: mostly ready, short stalls, now and then a long one
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left == 0) begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 60) begin
            rsp_tready <= 1'b1;
            stall_left = $urandom_range(1, 8);
         end else if (stall_pick < 92) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(10, 30);
         end
      end else begin
         stall_left--;
      end
   end

   // --------------------------------------------------------------- checker

   task automatic note_failure(string what, stream_byte_type want);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display({"ERROR %0t: %s: expected byte %02h last %0b error %0b, ",
                   "got byte %02h last %0b error %0b"},
                  $realtime, what, want.data, want.last, want.err,
                  rsp_tdata, rsp_tlast, rsp_tuser);
   endtask

   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            note_failure("response with no request pending", '0);
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_tdata !== want.data || rsp_tlast !== want.last || rsp_tuser !== want.err)
               note_failure("response mismatch", want);
         end
      end
   end

   // ----------------------------------------------------------------- tests

   task automatic test_raw_fields();
      send_request(bpe_pkg::OP_RAW, 32'h0000_0001, 6'd1, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_RAW, 32'hFFFF_FFFF, 6'd32, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_RAW, 32'h0000_0000, 6'd32, 6'd0, 6'd0);
      // bits above the width must not leak into the stream
      send_request(bpe_pkg::OP_RAW, 32'hFFFF_FFE5, 6'd5, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_RAW, 32'h0000_00A5, 6'd8, 6'd63, 6'd63);
   endtask

   task automatic test_index_codes();
      send_request(bpe_pkg::OP_INDEX, 32'd0, 6'd0, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_INDEX, 32'd0, 6'd0, 6'd0, 6'd1);
      send_request(bpe_pkg::OP_INDEX, 32'd0, 6'd0, 6'd0, 6'd2);
      send_request(bpe_pkg::OP_INDEX, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63);
      send_request(bpe_pkg::OP_ESCAPE, 32'd0, 6'd0, 6'd0, 6'd0);
   endtask

   task automatic test_block_values();
      send_request(bpe_pkg::OP_VALUE, 32'h0000_0003, 6'd32, 6'd8, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'hFFFF_FFFE, 6'd32, 6'd8, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'h8000_0000, 6'd32, 6'd16, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'h1234_5678, 6'd32, 6'd1, 6'd0);
      // zero block size means the whole width: raw packing
      send_request(bpe_pkg::OP_VALUE, 32'hDEAD_BEEF, 6'd20, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'h0000_0002, 6'd2, 6'd1, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'h0000_0155, 6'd10, 6'd10, 6'd0);
   endtask

   task automatic test_invalid_requests();
      send_request(OP_SPARE_5, 32'h0000_00FF, 6'd8, 6'd0, 6'd0);
      send_request(OP_SPARE_6, 32'h0000_00FF, 6'd8, 6'd0, 6'd0);
      send_request(OP_SPARE_7, 32'h0000_00FF, 6'd8, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_RAW, 32'h0000_00FF, 6'd0, 6'd0, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'h0000_0FFF, 6'd12, 6'd13, 6'd0);
      send_request(bpe_pkg::OP_VALUE, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd0);
   endtask

   task automatic test_flush();
      send_request(bpe_pkg::OP_FLUSH, 32'd0, 6'd0, 6'd0, 6'd0);
      // nothing pending now: no byte comes out
      send_request(bpe_pkg::OP_FLUSH, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63);
   endtask

   task automatic random_request();
      int r;
      int nb;
      int bs;
      int cut;
      logic [63:0] bits;
      logic [63:0] keep;
      r = $urandom_range(0, 99);
      nb = $urandom_range(1, 32);
      bits = {32'd0, $urandom()};
      if (r < 25) begin
         send_request(bpe_pkg::OP_RAW, bits[31:0], 6'(nb), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
      end else if (r < 45) begin
         send_request(bpe_pkg::OP_INDEX, bits[31:0], 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)),
                      ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 9)));
      end else if (r < 53) begin
         send_request(bpe_pkg::OP_ESCAPE, bits[31:0], 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end else if (r < 85) begin
         // sign-extend above a random point so values end early at varied blocks
         cut = $urandom_range(1, nb);
         keep = low_mask(cut);
         bits = (bits & keep) | (bits[cut-1] ? ~keep : 64'd0);
         bits = bits ^ ({32'd0, $urandom()} & ~low_mask(nb));
         bs = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, nb);
         send_request(bpe_pkg::OP_VALUE, bits[31:0], 6'(nb), 6'(bs),
                      6'($urandom_range(0, 63)));
      end else if (r < 92) begin
         send_request(bpe_pkg::OP_FLUSH, bits[31:0], 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end else begin
         case ($urandom_range(0, 2))
            0: send_request(OP_SPARE_5 + 3'($urandom_range(0, 2)), bits[31:0], 6'(nb),
                            6'd0, 6'd0);
            1: send_request(($urandom_range(0, 1) == 0) ? bpe_pkg::OP_RAW : bpe_pkg::OP_VALUE,
                            bits[31:0],
                            ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63)),
                            6'($urandom_range(0, 63)), 6'd0);
            default: send_request(bpe_pkg::OP_VALUE, bits[31:0], 6'(nb),
                                  6'($urandom_range(nb + 1, 63)), 6'd0);
         endcase
      end
   endtask

   task automatic test_random_stream(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0) begin
            case ((i / 20) % 4)
               0: begin gaps_on = 1'b1; stalls_on = 1'b1; end
               1: begin gaps_on = 1'b0; stalls_on = 1'b0; end
               2: begin gaps_on = 1'b1; stalls_on = 1'b0; end
               default: begin gaps_on = 1'b0; stalls_on = 1'b1; end
            endcase
         end
         // hold off once until the response side has caught up
         if (i == count / 2)
            wait_drained();
         random_request();
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin
      pack_byte = '0;
      pack_free = 8;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_raw_fields();
      test_index_codes();
      test_block_values();
      test_invalid_requests();
      test_flush();
      test_random_stream(RANDOM_REQUESTS);

      wait_drained();
      repeat (50) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         failures++;
         $display("ERROR: %0d expected responses never arrived", expected_bytes.size());
      end

      $display("Sent %0d requests (%0d malformed) over raw, index, escape, value and flush",
               requests_sent, invalid_sent);
      $display("Checked %0d response bytes with random gaps and backpressure", bytes_checked);
      if (failures == 0)
         $display("bit_packing_value_index_encoder regression: pass");
      else
         $display("bit_packing_value_index_encoder regression: fail");
      $finish;
   end

endmodule
